@@ rtl/core/ttavg_pkg.sv @@
// Shared constants, types and tables of the temporal threshold average core.
package ttavg_pkg;

   localparam int SAMPLE_W = 8;
   localparam int RADIUS_W = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam int MAX_RADIUS_DEFAULT = 2;
   localparam int FRAME_SLOTS = 5;
   localparam int CENTER_SLOT = 2;

   // Sum of up to five samples plus half the count.
   localparam int SUM_W = 11;
   localparam int CNT_W = 3;
   localparam int FRAC_W = 16;
   localparam int RECIP_W = FRAC_W + 1;
   localparam int PROD_W = SUM_W + RECIP_W;

   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LUMA_LIMIT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHROMA_LIMIT = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd1;
   localparam logic [SAMPLE_W-1:0] LUMA_LIMIT_RESET = 8'd4;
   localparam logic [SAMPLE_W-1:0] CHROMA_LIMIT_RESET = 8'd8;

   typedef struct packed {
      logic                keep;
      logic [SAMPLE_W-1:0] value;
   } lane_out_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // floor(2^FRAC_W / count); counts that never occur map to zero
   function automatic logic [RECIP_W-1:0] ttavg_recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      unique case (cnt)
         3'd1:    r = 17'd65536;
         3'd2:    r = 17'd32768;
         3'd3:    r = 17'd21845;
         3'd4:    r = 17'd16384;
         3'd5:    r = 17'd13107;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/ttavg_if.sv @@
// Handshake channels of the temporal threshold average core.
interface ttavg_req_if;
   import ttavg_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] luma_m2;
   logic [SAMPLE_W-1:0] luma_m1;
   logic [SAMPLE_W-1:0] luma_center;
   logic [SAMPLE_W-1:0] luma_p1;
   logic [SAMPLE_W-1:0] luma_p2;
   logic [SAMPLE_W-1:0] chroma_m2;
   logic [SAMPLE_W-1:0] chroma_m1;
   logic [SAMPLE_W-1:0] chroma_center;
   logic [SAMPLE_W-1:0] chroma_p1;
   logic [SAMPLE_W-1:0] chroma_p2;

   modport source (output valid, luma_m2, luma_m1, luma_center, luma_p1, luma_p2,
                   chroma_m2, chroma_m1, chroma_center, chroma_p1, chroma_p2,
                   input ready);
   modport sink (input valid, luma_m2, luma_m1, luma_center, luma_p1, luma_p2,
                 chroma_m2, chroma_m1, chroma_center, chroma_p1, chroma_p2,
                 output ready);
endinterface

interface ttavg_rsp_if;
   import ttavg_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] luma_result;
   logic [SAMPLE_W-1:0] chroma_result;

   modport source (output valid, luma_result, chroma_result, input ready);
   modport sink (input valid, luma_result, chroma_result, output ready);
endinterface

interface ttavg_csr_if;
   import ttavg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

@@ rtl/core/ttavg_lane.sv @@
// One lane: closeness and window test of a single frame sample.
module ttavg_lane #(
   parameter int OFFSET = 0
) (
   input  logic [ttavg_pkg::SAMPLE_W-1:0] sample,
   input  logic [ttavg_pkg::SAMPLE_W-1:0] center,
   input  logic [ttavg_pkg::SAMPLE_W-1:0] limit,
   input  logic [ttavg_pkg::RADIUS_W-1:0] radius,
   output ttavg_pkg::lane_out_type        lane_out
);
   import ttavg_pkg::*;

   logic [SAMPLE_W-1:0] diff;
   logic                in_window;

   assign diff = (sample > center) ? sample - center : center - sample;
   assign in_window = RADIUS_W'(OFFSET) <= radius;

   always_comb begin
      lane_out.keep  = in_window && (diff <= limit);
      lane_out.value = lane_out.keep ? sample : '0;
   end

endmodule

@@ rtl/core/ttavg_merge.sv @@
// Merge stage: sums kept lanes, then divides by the count with rounding.
module ttavg_merge #(
   parameter int MAX_RADIUS = ttavg_pkg::MAX_RADIUS_DEFAULT,
   localparam int LANES = 2 * MAX_RADIUS + 1
) (
   input  logic                           clock,
   input  ttavg_pkg::stage_en_type        stage_en,
   input  ttavg_pkg::lane_out_type        lanes [LANES],
   output logic [ttavg_pkg::SAMPLE_W-1:0] result
);
   import ttavg_pkg::*;

   logic [SUM_W-1:0]    sum_sel;
   logic [CNT_W-1:0]    cnt_sel;
   logic [SUM_W-1:0]    n_in, n_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [PROD_W-1:0]   prod;
   logic [SUM_W-1:0]    q0_in, q0_ff;
   logic [SUM_W-1:0]    n2_ff;
   logic [CNT_W-1:0]    cnt2_ff;
   logic [SUM_W-1:0]    qc;
   logic [SUM_W-1:0]    rem;
   logic [SUM_W-1:0]    quot;
   logic [SAMPLE_W-1:0] result_in, result_ff;

   always_comb begin
      sum_sel = '0;
      cnt_sel = '0;
      for (int k = 0; k < LANES; k++) begin
         sum_sel = sum_sel + SUM_W'(lanes[k].value);
         cnt_sel = cnt_sel + CNT_W'(lanes[k].keep);
      end
      n_in = sum_sel + SUM_W'(cnt_sel >> 1);
   end

   // reciprocal estimate is exact or one low
   assign prod  = PROD_W'(n_ff) * PROD_W'(ttavg_recip(cnt_ff));
   assign q0_in = prod[FRAC_W +: SUM_W];

   always_comb begin
      qc        = q0_ff * SUM_W'(cnt2_ff);
      rem       = n2_ff - qc;
      quot      = (rem >= SUM_W'(cnt2_ff)) ? q0_ff + SUM_W'(1) : q0_ff;
      result_in = quot[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         n_ff   <= n_in;
         cnt_ff <= cnt_sel;
      end
      if (stage_en.s2) begin
         q0_ff   <= q0_in;
         n2_ff   <= n_ff;
         cnt2_ff <= cnt_ff;
      end
      if (stage_en.s3) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

@@ rtl/core/temporal_threshold_average_core.sv @@
// Top level of the temporal threshold average core.
// Usage:
//   req_bus carries one item: luma and chroma samples of the frames from
//   two before to two after the center frame at one pixel position.
//   rsp_bus returns one item per request: the rounded mean of the samples
//   within window_radius frames whose distance from the center sample is
//   within the component's limit (the center always counts).
//   csr_bus writes window_radius, luma_limit, chroma_limit at indexes 0..2;
//   it is always ready and a write to another index is dropped. Write only
//   while the pipeline is empty.
// Timing:
//   Three register stages (s1, s2, s3): an item taken into s1 moves on to s2
//   and then s3, and rsp_bus.valid shows s3 holding it. One item per cycle
//   is sustained while rsp_bus is ready; the lanes test all frames at once
//   and the merge stage divides by count with a reciprocal multiply and one
//   correction step. When rsp_bus stalls, stages hold and bubbles fill first;
//   req_bus.ready drops only once every stage holds an item.
// Reset:
//   Synchronous; empties the pipeline and loads radius 1, limits 4 and 8.
module temporal_threshold_average_core #(
   parameter int MAX_RADIUS = ttavg_pkg::MAX_RADIUS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ttavg_req_if.sink  req_bus,
   ttavg_rsp_if.source rsp_bus,
   ttavg_csr_if.sink  csr_bus
);
   import ttavg_pkg::*;

   localparam int LANES = 2 * MAX_RADIUS + 1;

   logic [RADIUS_W-1:0] radius_ff;
   logic [SAMPLE_W-1:0] luma_limit_ff;
   logic [SAMPLE_W-1:0] chroma_limit_ff;
   logic [RADIUS_W-1:0] radius_eff;

   logic v1_ff, v2_ff, v3_ff;
   stage_en_type stage_en;

   logic [SAMPLE_W-1:0] luma_s   [FRAME_SLOTS];
   logic [SAMPLE_W-1:0] chroma_s [FRAME_SLOTS];
   lane_out_type luma_lanes   [LANES];
   lane_out_type chroma_lanes [LANES];

   assign radius_eff = (radius_ff > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_ff;

   always_comb begin
      stage_en.s3 = !v3_ff || rsp_bus.ready;
      stage_en.s2 = !v2_ff || stage_en.s3;
      stage_en.s1 = !v1_ff || stage_en.s2;
   end

   assign req_bus.ready = stage_en.s1;
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         radius_ff       <= RADIUS_RESET;
         luma_limit_ff   <= LUMA_LIMIT_RESET;
         chroma_limit_ff <= CHROMA_LIMIT_RESET;
      end else begin
         if (stage_en.s1) v1_ff <= req_bus.valid;
         if (stage_en.s2) v2_ff <= v1_ff;
         if (stage_en.s3) v3_ff <= v2_ff;
         if (csr_bus.valid) begin
            unique case (csr_bus.addr)
               CSR_RADIUS:       radius_ff       <= csr_bus.data[RADIUS_W-1:0];
               CSR_LUMA_LIMIT:   luma_limit_ff   <= csr_bus.data;
               CSR_CHROMA_LIMIT: chroma_limit_ff <= csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      luma_s[0]   = req_bus.luma_m2;
      luma_s[1]   = req_bus.luma_m1;
      luma_s[2]   = req_bus.luma_center;
      luma_s[3]   = req_bus.luma_p1;
      luma_s[4]   = req_bus.luma_p2;
      chroma_s[0] = req_bus.chroma_m2;
      chroma_s[1] = req_bus.chroma_m1;
      chroma_s[2] = req_bus.chroma_center;
      chroma_s[3] = req_bus.chroma_p1;
      chroma_s[4] = req_bus.chroma_p2;
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      localparam int SLOT = CENTER_SLOT - MAX_RADIUS + k;
      localparam int OFFSET = (k > MAX_RADIUS) ? k - MAX_RADIUS : MAX_RADIUS - k;

      ttavg_lane #(.OFFSET(OFFSET)) u_luma_lane (
         .sample   (luma_s[SLOT]),
         .center   (req_bus.luma_center),
         .limit    (luma_limit_ff),
         .radius   (radius_eff),
         .lane_out (luma_lanes[k])
      );

      ttavg_lane #(.OFFSET(OFFSET)) u_chroma_lane (
         .sample   (chroma_s[SLOT]),
         .center   (req_bus.chroma_center),
         .limit    (chroma_limit_ff),
         .radius   (radius_eff),
         .lane_out (chroma_lanes[k])
      );
   end

   ttavg_merge #(.MAX_RADIUS(MAX_RADIUS)) u_luma_merge (
      .clock    (clock),
      .stage_en (stage_en),
      .lanes    (luma_lanes),
      .result   (rsp_bus.luma_result)
   );

   ttavg_merge #(.MAX_RADIUS(MAX_RADIUS)) u_chroma_merge (
      .clock    (clock),
      .stage_en (stage_en),
      .lanes    (chroma_lanes),
      .result   (rsp_bus.chroma_result)
   );

endmodule
